/* src/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared constants and types of the addressable LED frame serializer.
// ----------------------------------------------------------------------------
package lfs_pkg;

    // Default length of the frame store in pixels.
    localparam int LFS_MAX_LEDS = 64;

    // Width of chain lengths and fill bounds; covers every store length up to 256.
    localparam int LFS_CNT_W = 9;

    // Width of one pixel: green, red, blue from the top byte down.
    localparam int LFS_PIX_W = 24;

    // Width of the timing registers and of the hold time.
    localparam int LFS_TICK_W = 16;

    // Command codes.
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_FILL  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_SHOW  = 3'd3;
    localparam logic [2:0] OP_MATCH = 3'd4;

    // Configuration register indexes (byte address divided by four).
    localparam logic [1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [1:0] REG_SHORT_TICKS = 2'd1;
    localparam logic [1:0] REG_LONG_TICKS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [6:0]            RST_LED_COUNT   = 7'd64;
    localparam logic [LFS_TICK_W-1:0] RST_SHORT_TICKS = 16'd12;
    localparam logic [LFS_TICK_W-1:0] RST_LONG_TICKS  = 16'd24;

    // Commands from the dispatcher to the bit sequencer.
    typedef struct packed {
        logic show;
        logic match;
    } t_ser_cmd;

endpackage

/* src/addressable_led_frame_serializer_top.sv */
// ----------------------------------------------------------------------------
// addressable_led_frame_serializer_top
// Frame store of 24-bit pixels and serializer of the WS2812B pulse train.
// ----------------------------------------------------------------------------
// A command word is taken on the command ports at a rising edge where start is
// high and busy is low. Write pixel and clear give no result and leave busy low.
// Fill walks the frame store one pixel a cycle and keeps busy high until the
// last pixel of the run is written; a fill that starts beyond the chain ends at
// once. Start show and a timer match event read the current pixel from the frame
// store RAM, whose read is registered; busy is high while that read is pending,
// and the result word is registered after it. The block takes its next word in
// the cycle in which that result is on the result ports.
// A match event at the end of the frame needs no read and gives its result in
// the cycle after acceptance without raising busy. A match event while no
// frame runs gives nothing. Each result is on o_pin_level, o_hold_ticks and
// o_frame_done for exactly one cycle, marked by o_valid; the receiver cannot
// hold it off. The APB port holds led_count, short_ticks and long_ticks at byte
// addresses 0, 4 and 8, and pready is always high. Reset restores the register
// defaults, stops any frame and blanks the store at once through per-pixel
// valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module addressable_led_frame_serializer_top
    import lfs_pkg::*;
#(
    parameter int MAX_LEDS = LFS_MAX_LEDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command channel.
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_operation,
    input  logic [7:0]            i_led_index,
    input  logic [7:0]            i_fill_count,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    // Result channel.
    output logic                  o_valid,
    output logic                  o_pin_level,
    output logic [LFS_TICK_W-1:0] o_hold_ticks,
    output logic                  o_frame_done,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FILL = 1'b1;

    // Configuration registers.
    logic [6:0]            r_led_count;
    logic [LFS_TICK_W-1:0] r_short_ticks;
    logic [LFS_TICK_W-1:0] r_long_ticks;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count   <= RST_LED_COUNT;
            r_short_ticks <= RST_SHORT_TICKS;
            r_long_ticks  <= RST_LONG_TICKS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LED_COUNT:   r_led_count   <= pwdata[6:0];
                REG_SHORT_TICKS: r_short_ticks <= pwdata[LFS_TICK_W-1:0];
                REG_LONG_TICKS:  r_long_ticks  <= pwdata[LFS_TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LED_COUNT:   prdata = {25'd0, r_led_count};
            REG_SHORT_TICKS: prdata = {16'd0, r_short_ticks};
            REG_LONG_TICKS:  prdata = {16'd0, r_long_ticks};
            default:         prdata = 32'd0;
        endcase
    end

    // Effective chain length: a count of zero acts as one, and the count is
    // limited to the size of the store.
    logic [LFS_CNT_W-1:0] chain_len;

    always_comb begin
        if (r_led_count == 7'd0) begin
            chain_len = LFS_CNT_W'(1);
        end else if (LFS_CNT_W'(r_led_count) > LFS_CNT_W'(MAX_LEDS)) begin
            chain_len = LFS_CNT_W'(MAX_LEDS);
        end else begin
            chain_len = LFS_CNT_W'(r_led_count);
        end
    end

    // Command decode.
    logic                 serial_busy;
    logic                 accept;
    logic                 idx_in_chain;
    logic [LFS_PIX_W-1:0] colour;
    logic [LFS_CNT_W-1:0] fill_sum;
    logic [LFS_CNT_W-1:0] fill_end;

    logic                 r_state, n_state;
    logic [LFS_CNT_W-1:0] r_fill_pos, n_fill_pos;
    logic [LFS_CNT_W-1:0] r_fill_end, n_fill_end;
    logic [LFS_PIX_W-1:0] r_fill_colour, n_fill_colour;

    assign busy         = (r_state != S_IDLE) || serial_busy;
    assign accept       = start && !busy;
    assign idx_in_chain = LFS_CNT_W'(i_led_index) < chain_len;
    assign colour       = {i_green, i_red, i_blue};
    assign fill_sum     = LFS_CNT_W'(i_led_index) + LFS_CNT_W'(i_fill_count);

    always_comb begin
        if (i_fill_count == 8'd0 || fill_sum > chain_len) begin
            fill_end = chain_len;
        end else begin
            fill_end = fill_sum;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_fill_pos    = r_fill_pos;
        n_fill_end    = r_fill_end;
        n_fill_colour = r_fill_colour;
        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_FILL && idx_in_chain) begin
                    n_state       = S_FILL;
                    n_fill_pos    = LFS_CNT_W'(i_led_index);
                    n_fill_end    = fill_end;
                    n_fill_colour = colour;
                end
            end
            S_FILL: begin
                n_fill_pos = r_fill_pos + LFS_CNT_W'(1);
                if (r_fill_pos + LFS_CNT_W'(1) == r_fill_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_fill_pos    <= n_fill_pos;
        r_fill_end    <= n_fill_end;
        r_fill_colour <= n_fill_colour;
    end

    // Frame store write port: the fill walk, or a single pixel write.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [LFS_PIX_W-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [LFS_PIX_W-1:0] ram_rdata;
    logic [AW-1:0]        led_pos;

    always_comb begin
        if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_fill_pos[AW-1:0];
            ram_wdata = r_fill_colour;
        end else begin
            ram_we    = accept && i_operation == OP_WRITE && idx_in_chain;
            ram_waddr = i_led_index[AW-1:0];
            ram_wdata = colour;
        end
    end

    // A show restarts at the first pixel; a match event reads the pixel in flight.
    assign ram_raddr = (i_operation == OP_SHOW) ? '0 : led_pos;

    lfs_ram #(
        .WIDTH (LFS_PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One valid bit per pixel: a pixel never written since reset or the last
    // clear reads as black. Clear and reset drop every bit at once.
    logic [MAX_LEDS-1:0] r_pix_valid, n_pix_valid;
    logic                r_rd_valid;
    logic                clear_cmd;

    assign clear_cmd = accept && i_operation == OP_CLEAR;

    always_comb begin
        n_pix_valid = r_pix_valid;
        if (clear_cmd) begin
            n_pix_valid = '0;
        end else if (ram_we) begin
            n_pix_valid[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= '0;
        end else begin
            r_pix_valid <= n_pix_valid;
        end
        r_rd_valid <= r_pix_valid[ram_raddr];
    end

    // Bit sequencer.
    t_ser_cmd             ser_cmd;
    logic [LFS_PIX_W-1:0] pixel;

    assign ser_cmd.show  = accept && i_operation == OP_SHOW;
    assign ser_cmd.match = accept && i_operation == OP_MATCH;
    assign pixel         = r_rd_valid ? ram_rdata : '0;

    lfs_serial #(
        .MAX_LEDS (MAX_LEDS)
    ) u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ser_cmd),
        .i_word        (pixel),
        .i_chain_len   (chain_len),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .o_led_pos     (led_pos),
        .o_busy        (serial_busy),
        .o_valid       (o_valid),
        .o_pin_level   (o_pin_level),
        .o_hold_ticks  (o_hold_ticks),
        .o_frame_done  (o_frame_done)
    );

endmodule

/* src/lfs_ram.sv */
// ----------------------------------------------------------------------------
// lfs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lfs_serial.sv */
// ----------------------------------------------------------------------------
// lfs_serial
// Bit sequencer: keeps the frame position and produces pin level and hold time.
// ----------------------------------------------------------------------------
module lfs_serial
    import lfs_pkg::*;
#(
    parameter int MAX_LEDS = LFS_MAX_LEDS,
    localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ser_cmd              i_cmd,
    input  logic [LFS_PIX_W-1:0]  i_word,
    input  logic [LFS_CNT_W-1:0]  i_chain_len,
    input  logic [LFS_TICK_W-1:0] i_short_ticks,
    input  logic [LFS_TICK_W-1:0] i_long_ticks,
    output logic [AW-1:0]         o_led_pos,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic                  o_pin_level,
    output logic [LFS_TICK_W-1:0] o_hold_ticks,
    output logic                  o_frame_done
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_LOW    = 2'd2;
    localparam logic [1:0] PH_FINISH = 2'd3;

    logic [1:0]            r_phase, n_phase;
    logic [2:0]            r_bit, n_bit;
    logic [1:0]            r_colour, n_colour;
    logic [AW-1:0]         r_led, n_led;
    logic                  r_pend, n_pend;
    logic                  r_valid, n_valid;
    logic                  r_pin, n_pin;
    logic [LFS_TICK_W-1:0] r_hold, n_hold;
    logic                  r_done, n_done;

    logic [4:0] bit_sel;
    logic       cur_bit;

    // The pixel holds green, red, blue from the top; each byte goes out MSB first.
    assign bit_sel = 5'd23 - {r_colour, r_bit};
    assign cur_bit = i_word[bit_sel];

    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_colour = r_colour;
        n_led    = r_led;
        n_pend   = 1'b0;
        n_valid  = 1'b0;
        n_pin    = r_pin;
        n_hold   = r_hold;
        n_done   = r_done;
        if (r_pend) begin
            n_valid = 1'b1;
            n_done  = 1'b0;
            if (r_phase == PH_HIGH) begin
                n_pin   = 1'b0;
                n_hold  = cur_bit ? i_short_ticks : i_long_ticks;
                n_phase = PH_LOW;
                if (r_bit != 3'd7) begin
                    n_bit = r_bit + 3'd1;
                end else begin
                    n_bit = 3'd0;
                    if (r_colour != 2'd2) begin
                        n_colour = r_colour + 2'd1;
                    end else begin
                        n_colour = 2'd0;
                        if ((LFS_CNT_W'(r_led) + LFS_CNT_W'(1)) < i_chain_len) begin
                            n_led = r_led + AW'(1);
                        end else begin
                            n_led   = '0;
                            n_phase = PH_FINISH;
                        end
                    end
                end
            end else begin
                // Low part ended, or a show that was entered as a low phase.
                n_pin   = 1'b1;
                n_hold  = cur_bit ? i_long_ticks : i_short_ticks;
                n_phase = PH_HIGH;
            end
        end else if (i_cmd.show) begin
            n_bit    = 3'd0;
            n_colour = 2'd0;
            n_led    = '0;
            n_phase  = PH_LOW;
            n_pend   = 1'b1;
        end else if (i_cmd.match) begin
            case (r_phase)
                PH_HIGH, PH_LOW: begin
                    n_pend = 1'b1;
                end
                PH_FINISH: begin
                    n_valid  = 1'b1;
                    n_pin    = 1'b0;
                    n_hold   = '0;
                    n_done   = 1'b1;
                    n_phase  = PH_IDLE;
                    n_bit    = 3'd0;
                    n_colour = 2'd0;
                    n_led    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= 3'd0;
            r_colour <= 2'd0;
            r_led    <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_colour <= n_colour;
            r_led    <= n_led;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
        r_pin  <= n_pin;
        r_hold <= n_hold;
        r_done <= n_done;
    end

    assign o_led_pos    = r_led;
    assign o_busy       = r_pend;
    assign o_valid      = r_valid;
    assign o_pin_level  = r_pin;
    assign o_hold_ticks = r_hold;
    assign o_frame_done = r_done;

endmodule

/* dv/lfs_frame_checker.sv */
// ----------------------------------------------------------------------------
// lfs_frame_checker
// Watches the command, result and register channels of the LED frame
// serializer, keeps its own copy of the frame store and the pulse sequencer,
// and compares every result word with the pulse it predicts.
// ----------------------------------------------------------------------------
module lfs_frame_checker
    import lfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [2:0]            i_operation,
    input  logic [7:0]            i_led_index,
    input  logic [7:0]            i_fill_count,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic                  i_valid,
    input  logic                  i_pin_level,
    input  logic [LFS_TICK_W-1:0] i_hold_ticks,
    input  logic                  i_frame_done,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [3:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output logic                  o_frame_running
);

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_HIGH,
        LINE_LOW,
        LINE_FINISH
    } t_line_phase;

    typedef struct packed {
        logic                  pin_level;
        logic [LFS_TICK_W-1:0] hold_ticks;
        logic                  frame_done;
    } t_pulse;

    logic [LFS_PIX_W-1:0]  pixel_mem [LFS_MAX_LEDS];
    t_line_phase           line_phase;
    logic [2:0]            bit_pos;
    logic [1:0]            colour_pos;
    logic [5:0]            led_pos;
    logic [6:0]            led_count_reg;
    logic [LFS_TICK_W-1:0] short_reg;
    logic [LFS_TICK_W-1:0] long_reg;
    t_pulse                pulse_q [$];
    int                    mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // A count of zero still means one LED; anything beyond the store is cut.
    function automatic int unsigned chain_len();
        if (led_count_reg == 7'd0) return 1;
        if (led_count_reg > LFS_MAX_LEDS) return LFS_MAX_LEDS;
        return int'(led_count_reg);
    endfunction

    // Pixels are green, red, blue from the top byte down, each byte MSB first.
    function automatic logic cursor_bit();
        int unsigned pos;
        pos = 23 - (int'(colour_pos) * 8 + int'(bit_pos));
        return pixel_mem[led_pos][5'(pos)];
    endfunction

    task automatic push_pulse(input logic level, input logic [LFS_TICK_W-1:0] hold,
                              input logic done);
        t_pulse p;
        p.pin_level  = level;
        p.hold_ticks = hold;
        p.frame_done = done;
        pulse_q.push_back(p);
    endtask

    task automatic reset_model();
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
        line_phase    = LINE_IDLE;
        bit_pos       = '0;
        colour_pos    = '0;
        led_pos       = '0;
        led_count_reg = RST_LED_COUNT;
        short_reg     = RST_SHORT_TICKS;
        long_reg      = RST_LONG_TICKS;
        pulse_q.delete();
    endtask

    task automatic apply_reg_write();
        case (i_paddr[3:2])
            REG_LED_COUNT:   led_count_reg = i_pwdata[6:0];
            REG_SHORT_TICKS: short_reg     = i_pwdata[LFS_TICK_W-1:0];
            REG_LONG_TICKS:  long_reg      = i_pwdata[LFS_TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_word();
        int unsigned          n;
        int unsigned          last;
        logic                 b;
        logic [LFS_PIX_W-1:0] colour;
        n      = chain_len();
        colour = {i_green, i_red, i_blue};
        case (i_operation)
            OP_WRITE: begin
                if (i_led_index < n) pixel_mem[i_led_index[5:0]] = colour;
            end
            OP_FILL: begin
                if (i_led_index < n) begin
                    last = (i_fill_count == 8'd0) ? n
                         : 32'(i_led_index) + 32'(i_fill_count);
                    if (last > n) last = n;
                    for (int unsigned i = 32'(i_led_index); i < last; i++)
                        pixel_mem[6'(i)] = colour;
                end
            end
            OP_CLEAR: begin
                foreach (pixel_mem[i]) pixel_mem[i] = '0;
            end
            OP_SHOW: begin
                bit_pos    = '0;
                colour_pos = '0;
                led_pos    = '0;
                line_phase = LINE_HIGH;
                push_pulse(1'b1, cursor_bit() ? long_reg : short_reg, 1'b0);
            end
            OP_MATCH: begin
                case (line_phase)
                    LINE_HIGH: begin
                        b = cursor_bit();
                        push_pulse(1'b0, b ? short_reg : long_reg, 1'b0);
                        line_phase = LINE_LOW;
                        if (bit_pos < 3'd7) begin
                            bit_pos++;
                        end else begin
                            bit_pos = '0;
                            if (colour_pos < 2'd2) begin
                                colour_pos++;
                            end else begin
                                colour_pos = '0;
                                if (int'(led_pos) + 1 < n) begin
                                    led_pos++;
                                end else begin
                                    led_pos    = '0;
                                    line_phase = LINE_FINISH;
                                end
                            end
                        end
                    end
                    LINE_LOW: begin
                        push_pulse(1'b1, cursor_bit() ? long_reg : short_reg, 1'b0);
                        line_phase = LINE_HIGH;
                    end
                    LINE_FINISH: begin
                        push_pulse(1'b0, '0, 1'b1);
                        line_phase = LINE_IDLE;
                        bit_pos    = '0;
                        colour_pos = '0;
                        led_pos    = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // Results leave before the word accepted at the same edge can add one.
    always @(posedge i_clk) begin
        t_pulse want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_valid) begin
                if (pulse_q.size() == 0) begin
                    report_mismatch("result word with none expected",
                                    32'(i_hold_ticks), 0);
                end else begin
                    want = pulse_q.pop_front();
                    if (i_pin_level !== want.pin_level)
                        report_mismatch("pin_level", 32'(i_pin_level),
                                        32'(want.pin_level));
                    if (i_hold_ticks !== want.hold_ticks)
                        report_mismatch("hold_ticks", 32'(i_hold_ticks),
                                        32'(want.hold_ticks));
                    if (i_frame_done !== want.frame_done)
                        report_mismatch("frame_done", 32'(i_frame_done),
                                        32'(want.frame_done));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) apply_reg_write();
            if (i_start && !i_busy) apply_word();
        end
        o_pending       <= pulse_q.size();
        o_frame_running <= (line_phase != LINE_IDLE);
    end

endmodule

/* dv/tb_addressable_led_frame_serializer_top.sv */
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_serializer_top
// Stimulus and verdict for the LED frame serializer. A short directed run
// covers the store edges and the odd commands, then randomised phases, each
// with its own chain length and pulse timing, send pixel updates, shows and
// long runs of timer matches. The checker beside the block does all checking.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_serializer_top;
    import lfs_pkg::*;

    // Number of random command words that do real work before we stop.
    localparam int RANDOM_WORDS = 450;

    // Command codes that the block has no use for; it must ignore them.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] index;
        logic [7:0] count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            i_operation;
    logic [7:0]            i_led_index;
    logic [7:0]            i_fill_count;
    logic [7:0]            i_red;
    logic [7:0]            i_green;
    logic [7:0]            i_blue;
    logic                  o_valid;
    logic                  o_pin_level;
    logic [LFS_TICK_W-1:0] o_hold_ticks;
    logic                  o_frame_done;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [3:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending;
    logic                  frame_running;

    // Stimulus-side view of the chain, used only to aim indexes at it.
    int unsigned           chain_now;
    bit                    gaps_on;
    int                    words_sent;
    int                    phase_no;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    addressable_led_frame_serializer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_led_index  (i_led_index),
        .i_fill_count (i_fill_count),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_pin_level  (o_pin_level),
        .o_hold_ticks (o_hold_ticks),
        .o_frame_done (o_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    lfs_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_led_index     (i_led_index),
        .i_fill_count    (i_fill_count),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_valid         (o_valid),
        .i_pin_level     (o_pin_level),
        .i_hold_ticks    (o_hold_ticks),
        .i_frame_done    (o_frame_done),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_frame_running (frame_running)
    );

    function automatic t_cmd_word cmd(input logic [2:0] op, input logic [7:0] index,
                                      input logic [7:0] count, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue);
        t_cmd_word w;
        w.op    = op;
        w.index = index;
        w.count = count;
        w.red   = red;
        w.green = green;
        w.blue  = blue;
        return w;
    endfunction

    // A random word of the given kind. Indexes mostly land inside the chain so
    // that writes and fills take effect, but now and then they may fall
    // anywhere in the byte. Fill counts favour short runs, with the occasional
    // "to the end" and the occasional wide random count.
    function automatic t_cmd_word random_word(input logic [2:0] op);
        t_cmd_word w;
        w.op = op;
        if ($urandom_range(0, 3) == 0) w.index = 8'($urandom_range(0, 255));
        else                           w.index = 8'($urandom_range(0, chain_now - 1));
        case ($urandom_range(0, 3))
            0:       w.count = 8'd0;
            1:       w.count = 8'($urandom_range(0, 255));
            default: w.count = 8'($urandom_range(1, 4));
        endcase
        w.red   = 8'($urandom_range(0, 255));
        w.green = 8'($urandom_range(0, 255));
        w.blue  = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Noise: codes the block must ignore, or a match event that may arrive
    // while no frame is running.
    function automatic t_cmd_word noise_word();
        t_cmd_word w;
        w = random_word(OP_MATCH);
        case ($urandom_range(0, 3))
            0:       w.op = OP_SPARE_A;
            1:       w.op = OP_SPARE_B;
            2:       w.op = OP_SPARE_C;
            default: w.op = OP_MATCH;
        endcase
        return w;
    endfunction

    // Called at a falling edge. An optional idle gap comes first, then the
    // word is presented with start high until a rising edge sees busy low.
    // We return at the next falling edge with start still high, so that a
    // following word can be presented back to back without start dropping;
    // whoever does not send next must lower start.
    task automatic send_word(input t_cmd_word w);
        int gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= w.op;
        i_led_index  <= w.index;
        i_fill_count <= w.count;
        i_red        <= w.red;
        i_green      <= w.green;
        i_blue       <= w.blue;
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
    endtask

    // Registers are only touched once the block has gone quiet: every
    // predicted result has arrived and any fill walk has finished. An extra
    // wait covers a frame-end result that never raises busy.
    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes all three registers back to back over the APB port. Each write
    // is a setup phase followed by an access phase; psel stays up across the
    // batch and is dropped once at the end.
    task automatic write_config(input logic [6:0] count, input logic [15:0] short_t,
                                input logic [15:0] long_t);
        logic [1:0]  reg_idx [3];
        logic [31:0] reg_val [3];
        reg_idx = '{REG_LED_COUNT, REG_SHORT_TICKS, REG_LONG_TICKS};
        reg_val = '{{25'd0, count}, {16'd0, short_t}, {16'd0, long_t}};
        settle();
        for (int k = 0; k < 3; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx[k], 2'b00};
            pwdata  <= reg_val[k];
            @(negedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (count == 7'd0)             chain_now = 1;
        else if (count > LFS_MAX_LEDS) chain_now = LFS_MAX_LEDS;
        else                           chain_now = 32'(count);
    endtask

    function automatic logic [15:0] random_ticks();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // Short chains dominate so that frames actually reach their end within a
    // phase; long and out-of-range lengths still turn up now and then.
    function automatic logic [6:0] random_led_count();
        case ($urandom_range(0, 9))
            0:       return 7'd64;
            1:       return 7'($urandom_range(65, 127));
            2:       return 7'd0;
            default: return 7'($urandom_range(1, 3));
        endcase
    endfunction

    // One phase of random traffic. While a frame runs the stream is mostly
    // match events, which walk the sequencer through every bit, with pixel
    // updates, restarts and noise mixed in. With no frame running it loads
    // pixels, clears, starts shows, adds noise. Ignored words do not count.
    task automatic run_phase(input int quota);
        int        done_here;
        int        roll;
        bit        counts;
        t_cmd_word w;
        done_here = 0;
        while (done_here < quota && words_sent < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            if (frame_running) begin
                if (roll < 88)      w = random_word(OP_MATCH);
                else if (roll < 93) w = random_word(OP_WRITE);
                else if (roll < 95) w = random_word(OP_FILL);
                else if (roll < 96) w = random_word(OP_SHOW);
                else if (roll < 97) w = random_word(OP_CLEAR);
                else                w = noise_word();
            end else begin
                if (roll < 35)      w = random_word(OP_SHOW);
                else if (roll < 65) w = random_word(OP_WRITE);
                else if (roll < 80) w = random_word(OP_FILL);
                else if (roll < 84) w = random_word(OP_CLEAR);
                else                w = noise_word();
            end
            counts = (w.op == OP_MATCH) ? frame_running
                   : (w.op != OP_SPARE_A && w.op != OP_SPARE_B && w.op != OP_SPARE_C);
            send_word(w);
            if (counts) begin
                done_here++;
                words_sent++;
            end
        end
    endtask

    // Hard stop in case the block wedges or a result never turns up.
    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_WRITE;
        i_led_index  = '0;
        i_fill_count = '0;
        i_red        = '0;
        i_green      = '0;
        i_blue       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        chain_now    = LFS_MAX_LEDS;
        gaps_on      = 1'b1;
        words_sent   = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run at the reset register values (64 LEDs, 12/24).
        // Writes at both ends of the chain, then just past it and at the top
        // of the index range, which must be ignored.
        send_word(cmd(OP_WRITE, 8'd0,   8'd0, 8'h00, 8'hFF, 8'h00));
        send_word(cmd(OP_WRITE, 8'd63,  8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_word(cmd(OP_WRITE, 8'd64,  8'd0, 8'h12, 8'h34, 8'h56));
        send_word(cmd(OP_WRITE, 8'd255, 8'd0, 8'hAA, 8'h55, 8'hAA));
        // Fills: to the end, clipped at the end, starting beyond the chain
        // (nothing happens), and an ordinary short run.
        send_word(cmd(OP_FILL, 8'd60,  8'd0,   8'h12, 8'h34, 8'h56));
        send_word(cmd(OP_FILL, 8'd62,  8'd255, 8'hA5, 8'h5A, 8'hC3));
        send_word(cmd(OP_FILL, 8'd64,  8'd5,   8'hFF, 8'hFF, 8'hFF));
        send_word(cmd(OP_FILL, 8'd255, 8'd0,   8'hFF, 8'hFF, 8'hFF));
        send_word(cmd(OP_FILL, 8'd5,   8'd3,   8'h80, 8'h01, 8'hFE));
        // Unused codes and a match event with no frame running: no result.
        send_word(cmd(OP_SPARE_A, 8'd1, 8'd1, 8'h01, 8'h01, 8'h01));
        send_word(cmd(OP_SPARE_B, 8'd2, 8'd2, 8'h02, 8'h02, 8'h02));
        send_word(cmd(OP_SPARE_C, 8'd3, 8'd3, 8'h03, 8'h03, 8'h03));
        send_word(cmd(OP_MATCH,   8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        // Start a frame, step a few half-bits, then restart it mid-flight.
        send_word(cmd(OP_SHOW,  8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_SHOW,  8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        // Blank the store under a running frame; later bits must go out as 0.
        send_word(cmd(OP_CLEAR, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(cmd(OP_MATCH, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));

        // Random phases. The first three pin the register extremes: a single
        // LED with the narrowest and widest timing, a zero count with zero
        // timing, and the largest count with the timings the other way round.
        // Since a frame may still be running when a phase ends, a later phase
        // often shortens or lengthens the chain under a live frame.
        phase_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            case (phase_no)
                0:       write_config(7'd1,   16'd1,     16'hFFFF);
                1:       write_config(7'd0,   16'd0,     16'd0);
                2:       write_config(7'd127, 16'hFFFF,  16'd1);
                default: write_config(random_led_count(), random_ticks(), random_ticks());
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            run_phase($urandom_range(25, 60));
            phase_no++;
        end

        // Drain: wait for the last predicted result, then give the block a
        // little longer in case it produces something it should not.
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
